### rtl/ccs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccs_pkg;

  localparam logic [13:0] BASE_YEAR    = 14'd1900;
  localparam logic [2:0]  BASE_WEEKDAY = 3'd1;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [2:0]  WEEKDAY_NONE = 3'd7;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  // reciprocal constants, exact over the input ranges
  localparam logic [16:0] RECIP_1000 = 17'd67109;   // shift 26
  localparam logic [18:0] RECIP_60   = 19'd279621;  // shift 24
  localparam logic [11:0] RECIP_24   = 12'd2731;    // shift 16
  localparam logic [13:0] RECIP_100  = 14'd10486;   // shift 20

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] elapsed_ms;
    logic [15:0] shift_minutes;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
    logic [2:0]  load_weekday;
  } in_item_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [5:0]  rollover_flags;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_ACCEPT,
    CMD_TK_DIV, CMD_TK_REM, CMD_TK_SUB, CMD_TK_SEC, CMD_TK_MIN, CMD_TK_DAY,
    CMD_SH_DIV, CMD_SH_REM, CMD_SH_HDIV,
    CMD_ADD_MIN, CMD_SUB_MIN, CMD_ADD_HOUR, CMD_SUB_HOUR,
    CMD_FWD_INIT, CMD_BACK_INIT, CMD_FWD_STEP, CMD_BACK_STEP,
    CMD_WD_INIT, CMD_WD_WALK, CMD_WD_FIN, CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic fwd_end;
    logic back_end;
    logic wd_pre;
    logic wd_end;
  } dp_status_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] p;
    logic [7:0]  q;
    logic [14:0] back;
    logic        c100;
    p    = 28'(y) * 28'(RECIP_100);
    q    = p[27:20];
    back = 15'(q) * 15'd100;
    c100 = (15'(y) == back);
    return (y[1:0] == 2'b00 && !c100) || (c100 && q[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = 5'd28 + 5'(is_leap(y));
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // 8 is 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

endpackage
`default_nettype wire

### rtl/ccs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ccs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] elapsed_ms;
  logic [15:0] shift_minutes;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [4:0]  load_hour;
  logic [5:0]  load_minute;
  logic [5:0]  load_second;
  logic [2:0]  load_weekday;

  modport source (output valid, op, elapsed_ms, shift_minutes, load_year, load_month,
                  load_day, load_hour, load_minute, load_second, load_weekday,
                  input ready);
  modport sink (input valid, op, elapsed_ms, shift_minutes, load_year, load_month,
                load_day, load_hour, load_minute, load_second, load_weekday,
                output ready);
endinterface

interface ccs_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic [5:0]  rollover_flags;

  modport source (output valid, year, month, day, hour, minute, second, weekday,
                  rollover_flags, input ready);
  modport sink (input valid, year, month, day, hour, minute, second, weekday,
                rollover_flags, output ready);
endinterface
`default_nettype wire

### rtl/ccs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ccs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_op,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ccs_pkg::cmd_t         cmd,
  input  wire ccs_pkg::dp_status_t status
);
  import ccs_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_TK_DIV  = 19'h00002,
    S_TK_REM  = 19'h00004,
    S_TK_SUB  = 19'h00008,
    S_TK_SEC  = 19'h00010,
    S_TK_MIN  = 19'h00020,
    S_TK_DAY  = 19'h00040,
    S_SH_DIV  = 19'h00080,
    S_SH_REM  = 19'h00100,
    S_SH_HDIV = 19'h00200,
    S_SH_MIN  = 19'h00400,
    S_SH_HOUR = 19'h00800,
    S_DT_INIT = 19'h01000,
    S_FWD     = 19'h02000,
    S_BACK    = 19'h04000,
    S_WD_INIT = 19'h08000,
    S_WD_WALK = 19'h10000,
    S_WD_FIN  = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_add;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign is_add    = (op_r == OP_ADD);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd    = CMD_ACCEPT;
          op_nxt = in_op;
          case (in_op)
            OP_TICK: state_nxt = S_TK_DIV;
            OP_LOAD: state_nxt = S_DONE;
            default: state_nxt = S_SH_DIV;
          endcase
        end
      end
      S_TK_DIV: begin
        cmd = CMD_TK_DIV; state_nxt = S_TK_REM;
      end
      S_TK_REM: begin
        cmd = CMD_TK_REM; state_nxt = S_TK_SUB;
      end
      S_TK_SUB: begin
        cmd = CMD_TK_SUB; state_nxt = S_TK_SEC;
      end
      S_TK_SEC: begin
        cmd = CMD_TK_SEC; state_nxt = S_TK_MIN;
      end
      S_TK_MIN: begin
        cmd = CMD_TK_MIN; state_nxt = S_TK_DAY;
      end
      S_TK_DAY: begin
        cmd = CMD_TK_DAY; state_nxt = S_DONE;
      end
      S_SH_DIV: begin
        cmd = CMD_SH_DIV; state_nxt = S_SH_REM;
      end
      S_SH_REM: begin
        cmd = CMD_SH_REM; state_nxt = S_SH_HDIV;
      end
      S_SH_HDIV: begin
        cmd = CMD_SH_HDIV; state_nxt = S_SH_MIN;
      end
      S_SH_MIN: begin
        cmd = is_add ? CMD_ADD_MIN : CMD_SUB_MIN; state_nxt = S_SH_HOUR;
      end
      S_SH_HOUR: begin
        cmd = is_add ? CMD_ADD_HOUR : CMD_SUB_HOUR; state_nxt = S_DT_INIT;
      end
      S_DT_INIT: begin
        cmd = is_add ? CMD_FWD_INIT : CMD_BACK_INIT;
        if (status.d_zero) begin
          state_nxt = S_WD_INIT;
        end else begin
          state_nxt = is_add ? S_FWD : S_BACK;
        end
      end
      S_FWD: begin
        cmd = CMD_FWD_STEP;
        if (status.fwd_end) begin
          state_nxt = S_WD_INIT;
        end
      end
      S_BACK: begin
        cmd = CMD_BACK_STEP;
        if (status.back_end) begin
          state_nxt = S_WD_INIT;
        end
      end
      S_WD_INIT: begin
        cmd       = CMD_WD_INIT;
        state_nxt = status.wd_pre ? S_DONE : S_WD_WALK;
      end
      S_WD_WALK: begin
        cmd = CMD_WD_WALK;
        if (status.wd_end) begin
          state_nxt = S_WD_FIN;
        end
      end
      S_WD_FIN: begin
        cmd = CMD_WD_FIN; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd           = CMD_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TICK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_op == OP_LOAD) |=> (state_r == S_DONE))
    else $error("load request did not go straight to publish");

  a_pub_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside publish");

  a_tick_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TK_DIV) |-> ##6 (state_r == S_DONE))
    else $error("tick sequence length wrong");

endmodule
`default_nettype wire

### rtl/ccs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ccs_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ccs_pkg::cmd_t        cmd,
  input  wire ccs_pkg::in_item_t    in_item,
  output ccs_pkg::dp_status_t       status,
  output ccs_pkg::out_item_t        out_item
);
  import ccs_pkg::*;

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [9:0]  subms_r, subms_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [15:0] mins_r, mins_nxt;
  logic [10:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [6:0]  secs_r, secs_nxt;
  logic [1:0]  mc_r, mc_nxt;
  logic [5:0]  mv_r, mv_nxt;
  logic [4:0]  h_r, h_nxt;
  logic [5:0]  d_r, d_nxt;
  logic [6:0]  dd_r, dd_nxt;
  logic [13:0] yy_r, yy_nxt;
  logic [2:0]  acc_r, acc_nxt;
  out_item_t   out_r, out_nxt;

  logic [4:0]  cur_len;
  logic [3:0]  bk_month;
  logic [13:0] bk_year;
  logic [4:0]  bk_len;

  assign cur_len = month_len(month_r, year_r);

  always_comb begin
    bk_month = 4'd2;
    bk_year  = year_r;
    case (month_r) inside
      4'd1: begin
        bk_month = 4'd12;
        bk_year  = (year_r == 14'd0) ? YEAR_MAX : year_r - 14'd1;
      end
      [4'd2:4'd12]: bk_month = month_r - 4'd1;
      default:      bk_month = 4'd2;
    endcase
    bk_len = month_len(bk_month, bk_year);
  end

  assign status.d_zero   = (d_r == 6'd0);
  assign status.fwd_end  = (dd_r <= 7'(cur_len));
  assign status.back_end = (dd_r > 7'(d_r));
  assign status.wd_pre   = (year_r < BASE_YEAR);
  assign status.wd_end   = (yy_r == year_r);
  assign out_item        = out_r;

  always_comb begin
    logic [32:0] p1000;
    logic [34:0] p60;
    logic [22:0] p24;
    logic [16:0] r17;
    logic [10:0] ssum;
    logic [7:0]  s8;
    logic [6:0]  t7;
    logic [5:0]  t6;
    logic [5:0]  nd;
    logic [3:0]  a4;
    logic [8:0]  v9;
    logic        step_year;

    year_nxt = year_r;  month_nxt = month_r; day_nxt = day_r; hour_nxt = hour_r;
    minute_nxt = minute_r; second_nxt = second_r; wday_nxt = wday_r;
    subms_nxt = subms_r; flags_nxt = flags_r; ms_nxt = ms_r; mins_nxt = mins_r;
    q_nxt = q_r; rem_nxt = rem_r; secs_nxt = secs_r; mc_nxt = mc_r; mv_nxt = mv_r;
    h_nxt = h_r; d_nxt = d_r; dd_nxt = dd_r; yy_nxt = yy_r; acc_nxt = acc_r;
    out_nxt = out_r;

    p1000 = 33'(ms_r) * 33'(RECIP_1000);
    p60   = 35'(mins_r) * 35'(RECIP_60);
    p24   = 23'(q_r) * 23'(RECIP_24);
    r17   = 17'(ms_r) - 17'(q_r[6:0]) * 17'd1000;
    ssum  = 11'(subms_r) + 11'(rem_r);
    s8    = 8'(second_r) + 8'(secs_r);
    t7    = 7'd0;
    t6    = 6'd0;
    nd    = 6'(day_r) + 6'd1;
    a4    = 4'(acc_r) + 4'd1 + 4'(is_leap(yy_r));
    step_year = (month_r >= 4'd12);
    v9    = 9'(acc_r) + month_start(month_r)
          + 9'(month_r >= 4'd3 && month_r <= 4'd12 && is_leap(year_r))
          + 9'(day_r) + 9'd6 + 9'(BASE_WEEKDAY);

    case (cmd)
      CMD_ACCEPT: begin
        ms_nxt    = in_item.elapsed_ms;
        mins_nxt  = in_item.shift_minutes;
        flags_nxt = 6'd0;
        if (in_item.op == OP_LOAD) begin
          year_nxt   = in_item.load_year;
          month_nxt  = in_item.load_month;
          day_nxt    = in_item.load_day;
          hour_nxt   = in_item.load_hour;
          minute_nxt = in_item.load_minute;
          second_nxt = in_item.load_second;
          wday_nxt   = in_item.load_weekday;
        end
      end
      CMD_TK_DIV: begin
        q_nxt     = 11'(p1000[32:26]);
        flags_nxt = 6'h01;
      end
      CMD_TK_REM: rem_nxt = r17[9:0];
      CMD_TK_SUB: begin
        if (ssum >= 11'd1000) begin
          subms_nxt = 10'(ssum - 11'd1000);
          secs_nxt  = q_r[6:0] + 7'd1;
        end else begin
          subms_nxt = ssum[9:0];
          secs_nxt  = q_r[6:0];
        end
      end
      CMD_TK_SEC: begin
        mc_nxt = 2'd0;
        second_nxt = s8[5:0];
        if (s8 >= 8'd120) begin
          second_nxt = 6'(s8 - 8'd120); mc_nxt = 2'd2; flags_nxt[1] = 1'b1;
        end else if (s8 > 8'd59) begin
          second_nxt = 6'(s8 - 8'd60); mc_nxt = 2'd1; flags_nxt[1] = 1'b1;
        end
      end
      CMD_TK_MIN: begin
        if (flags_r[1]) begin
          t7 = 7'(minute_r) + 7'(mc_r);
          if (t7 > 7'd59) begin
            minute_nxt   = 6'(t7 - 7'd60);
            flags_nxt[2] = 1'b1;
            t6 = 6'(hour_r) + 6'd1;
            if (t6 > 6'd23) begin
              hour_nxt     = 5'd0;
              flags_nxt[3] = 1'b1;
            end else begin
              hour_nxt = t6[4:0];
            end
          end else begin
            minute_nxt = t7[5:0];
          end
        end
      end
      CMD_TK_DAY: begin
        if (flags_r[3]) begin
          wday_nxt = (wday_r >= 3'd6) ? 3'd0 : wday_r + 3'd1;
          if (nd > 6'(cur_len)) begin
            day_nxt      = 5'd1;
            flags_nxt[4] = 1'b1;
            if (step_year) begin
              month_nxt    = 4'd1;
              year_nxt     = (year_r >= YEAR_MAX) ? 14'd0 : year_r + 14'd1;
              flags_nxt[5] = 1'b1;
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            day_nxt = nd[4:0];
          end
        end
      end
      CMD_SH_DIV: q_nxt = p60[34:24];
      CMD_SH_REM: begin
        mv_nxt = 6'(mins_r - 16'(q_r) * 16'd60);
        d_nxt  = p24[21:16];
      end
      CMD_SH_HDIV: h_nxt = 5'(q_r - 11'(d_r) * 11'd24);
      CMD_ADD_MIN: begin
        t7 = 7'(minute_r) + 7'(mv_r);
        if (t7 >= 7'd120) begin
          minute_nxt = 6'(t7 - 7'd120); mc_nxt = 2'd2;
        end else if (t7 >= 7'd60) begin
          minute_nxt = 6'(t7 - 7'd60); mc_nxt = 2'd1;
        end else begin
          minute_nxt = t7[5:0]; mc_nxt = 2'd0;
        end
      end
      CMD_SUB_MIN: begin
        if (minute_r >= mv_r) begin
          minute_nxt = minute_r - mv_r;
        end else begin
          minute_nxt = 6'(7'(minute_r) + 7'd60 - 7'(mv_r));
          h_nxt      = h_r + 5'd1;
        end
      end
      CMD_ADD_HOUR: begin
        t6 = 6'(hour_r) + 6'(h_r) + 6'(mc_r);
        if (t6 >= 6'd48) begin
          hour_nxt = 5'(t6 - 6'd48); d_nxt = d_r + 6'd2;
        end else if (t6 >= 6'd24) begin
          hour_nxt = 5'(t6 - 6'd24); d_nxt = d_r + 6'd1;
        end else begin
          hour_nxt = t6[4:0];
        end
      end
      CMD_SUB_HOUR: begin
        if (hour_r >= h_r) begin
          hour_nxt = hour_r - h_r;
        end else begin
          hour_nxt = 5'(6'(hour_r) + 6'd24 - 6'(h_r));
          d_nxt    = d_r + 6'd1;
        end
      end
      CMD_FWD_INIT:  dd_nxt = 7'(day_r) + 7'(d_r);
      CMD_BACK_INIT: dd_nxt = 7'(day_r);
      CMD_FWD_STEP: begin
        if (dd_r <= 7'(cur_len)) begin
          day_nxt = dd_r[4:0];
        end else begin
          dd_nxt = dd_r - 7'(cur_len);
          if (step_year) begin
            month_nxt = 4'd1;
            year_nxt  = (year_r >= YEAR_MAX) ? 14'd0 : year_r + 14'd1;
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      CMD_BACK_STEP: begin
        if (dd_r > 7'(d_r)) begin
          day_nxt = 5'(dd_r - 7'(d_r));
        end else begin
          d_nxt     = 6'(7'(d_r) - dd_r);
          month_nxt = bk_month;
          year_nxt  = bk_year;
          dd_nxt    = 7'(bk_len);
        end
      end
      CMD_WD_INIT: begin
        if (year_r < BASE_YEAR) begin
          wday_nxt = WEEKDAY_NONE;
        end else begin
          yy_nxt  = BASE_YEAR;
          acc_nxt = 3'd0;
        end
      end
      CMD_WD_WALK: begin
        if (yy_r != year_r) begin
          acc_nxt = (a4 >= 4'd7) ? 3'(a4 - 4'd7) : a4[2:0];
          yy_nxt  = yy_r + 14'd1;
        end
      end
      CMD_WD_FIN: wday_nxt = mod7(v9);
      CMD_PUBLISH: begin
        out_nxt.year           = year_r;
        out_nxt.month          = month_r;
        out_nxt.day            = day_r;
        out_nxt.hour           = hour_r;
        out_nxt.minute         = minute_r;
        out_nxt.second         = second_r;
        out_nxt.weekday        = wday_r;
        out_nxt.rollover_flags = flags_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= BASE_YEAR;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
      wday_r   <= BASE_WEEKDAY;
      subms_r  <= 10'd0;
      flags_r  <= 6'd0;
    end else begin
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      wday_r   <= wday_nxt;
      subms_r  <= subms_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ms_r   <= ms_nxt;
    mins_r <= mins_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    secs_r <= secs_nxt;
    mc_r   <= mc_nxt;
    mv_r   <= mv_nxt;
    h_r    <= h_nxt;
    d_r    <= d_nxt;
    dd_r   <= dd_nxt;
    yy_r   <= yy_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  a_flags_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r[5:1] & ~flags_r[4:0]) == 5'd0)
    else $error("rollover flags not contiguous");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_WD_WALK) |-> (yy_r <= year_r))
    else $error("weekday walk passed current year");

  a_tick_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_TK_DIV) |=> (flags_r == 6'h01))
    else $error("tick flag not set");

endmodule
`default_nettype wire

### rtl/calendar_clock_with_shift.sv
`timescale 1ns / 1ps
`default_nettype none
// calendar clock with minute shift
// in_ch: one request per item, op 0 tick (elapsed_ms), 1 add and 2 subtract
//   shift_minutes, 3 load the clock from the load_* fields
// out_ch: one result per request, the clock after the request and the
//   rollover flags (nonzero only for ticks)
// accept to result: a load goes straight to publish; a tick runs divide, remainder,
//   subtract, second, minute and day steps; a shift runs divide, remainder, hour
//   divide, minute and hour steps, a date walk of one month per step when whole days
//   move, then a weekday walk over the years from 1900; years before 1900 skip the walk
// the weekday walk steps one year per cycle through a leap-year check
// one request is worked at a time; in_ch.ready is high while idle, also while
//   a finished result still sits in the output register
// a stalled receiver holds the result; the next result waits for it to drain
// reset: clock 1900-01-01 00:00:00, weekday 1, millisecond remainder zero,
//   no result pending
module calendar_clock_with_shift (
  input  wire logic clk,
  input  wire logic rst_n,
  ccs_in_if.sink    in_ch,
  ccs_out_if.source out_ch
);
  import ccs_pkg::*;

  cmd_t       cmd;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;

  assign in_item.op            = in_ch.op;
  assign in_item.elapsed_ms    = in_ch.elapsed_ms;
  assign in_item.shift_minutes = in_ch.shift_minutes;
  assign in_item.load_year     = in_ch.load_year;
  assign in_item.load_month    = in_ch.load_month;
  assign in_item.load_day      = in_ch.load_day;
  assign in_item.load_hour     = in_ch.load_hour;
  assign in_item.load_minute   = in_ch.load_minute;
  assign in_item.load_second   = in_ch.load_second;
  assign in_item.load_weekday  = in_ch.load_weekday;

  assign out_ch.year           = out_item.year;
  assign out_ch.month          = out_item.month;
  assign out_ch.day            = out_item.day;
  assign out_ch.hour           = out_item.hour;
  assign out_ch.minute         = out_item.minute;
  assign out_ch.second         = out_item.second;
  assign out_ch.weekday        = out_item.weekday;
  assign out_ch.rollover_flags = out_item.rollover_flags;

  ccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  ccs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
